FILE: hdl/fppr_pkg.sv
// Types, constants and control store for the fixed-point PI regulator.
`default_nettype none

package fppr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd4;

  localparam logic signed [12:0] S12_MAX       = 13'sd4095;
  localparam logic signed [12:0] S12_MIN       = -13'sd4096;
  localparam logic [12:0]        DEADBAND_FULL = 13'd4096;
  localparam int                 INTEG_FRAC    = 12;
  localparam int                 PROP_FRAC     = 10;

  typedef logic [3:0] pc_t;

  localparam pc_t STEP_WAIT  = 4'd0;
  localparam pc_t STEP_MUL_I = 4'd1;
  localparam pc_t STEP_INTEG = 4'd2;
  localparam pc_t STEP_MUL_P = 4'd3;
  localparam pc_t STEP_SUM   = 4'd4;
  localparam pc_t STEP_MUL_S = 4'd5;
  localparam pc_t STEP_MUL_D = 4'd6;
  localparam pc_t STEP_CLAMP = 4'd7;
  localparam pc_t STEP_OUT   = 4'd8;

  typedef enum logic [3:0] {
    OP_LOAD  = 4'd0,
    OP_MUL_I = 4'd1,
    OP_INTEG = 4'd2,
    OP_MUL_P = 4'd3,
    OP_SUM   = 4'd4,
    OP_MUL_S = 4'd5,
    OP_MUL_D = 4'd6,
    OP_CLAMP = 4'd7,
    OP_OUT   = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    C_NONE     = 3'd0,
    C_NO_ITEM  = 3'd1,
    C_MANUAL   = 3'd2,
    C_NO_DB    = 3'd3,
    C_OUT_BUSY = 3'd4
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt;
    logic  last;
  } uword_t;

  // Control store: one word per step; jump to tgt when cond holds.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      STEP_WAIT:  w = '{op: OP_LOAD,  cond: C_NO_ITEM,  tgt: STEP_WAIT,  last: 1'b0};
      STEP_MUL_I: w = '{op: OP_MUL_I, cond: C_MANUAL,   tgt: STEP_OUT,   last: 1'b0};
      STEP_INTEG: w = '{op: OP_INTEG, cond: C_NONE,     tgt: STEP_WAIT,  last: 1'b0};
      STEP_MUL_P: w = '{op: OP_MUL_P, cond: C_NONE,     tgt: STEP_WAIT,  last: 1'b0};
      STEP_SUM:   w = '{op: OP_SUM,   cond: C_NO_DB,    tgt: STEP_CLAMP, last: 1'b0};
      STEP_MUL_S: w = '{op: OP_MUL_S, cond: C_NONE,     tgt: STEP_WAIT,  last: 1'b0};
      STEP_MUL_D: w = '{op: OP_MUL_D, cond: C_NONE,     tgt: STEP_WAIT,  last: 1'b0};
      STEP_CLAMP: w = '{op: OP_CLAMP, cond: C_NONE,     tgt: STEP_WAIT,  last: 1'b0};
      STEP_OUT:   w = '{op: OP_OUT,   cond: C_OUT_BUSY, tgt: STEP_OUT,   last: 1'b1};
      default:    w = '{op: OP_LOAD,  cond: C_NONE,     tgt: STEP_WAIT,  last: 1'b1};
    endcase
    return w;
  endfunction

  // Saturate a 16-bit sample to S12.0.
  function automatic logic signed [12:0] sat12(input logic signed [15:0] v);
    logic signed [12:0] r;
    if (v > 16'(S12_MAX)) begin
      r = S12_MAX;
    end else if (v < 16'(S12_MIN)) begin
      r = S12_MIN;
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/fixed_point_pi_regulator.sv
// Fixed-point PI regulator: microcoded sequencer over a shared multiplier datapath.
//
// Usage: each input transfer carries feedback, target_value and auto_mode; each
// one yields exactly one output transfer with drive, saturated and active.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); register
// indexes 0..4 are prop_gain, integ_gain, drive_low, drive_high, deadband_width.
// Writes to other indexes are dropped.
// Steps: in auto mode the sequencer runs 8 steps after the input transfer
// (two gain multiplies, integrator clamp, sum, two deadband multiplies, output
// clamp, output load), 6 steps when the deadband does not apply; in manual mode
// 2 steps. One item is worked at a time: a new input transfer is taken only
// once the sequencer is back at its wait step.
// A nonzero deadband_width write starts a bit-serial 13-bit reciprocal; in_ready
// stays low until it finishes.
// The output register lets the next input transfer in while a result waits;
// when out_ready stays low the sequencer holds at its output step.
// Reset (synchronous, rst_n low) clears the configuration registers, the integrator, the last
// drive and the mode; after reset the block is in manual mode with drive 0.
`default_nettype none

module fixed_point_pi_regulator (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  signed [15:0]                   in_feedback,
  input  wire  signed [15:0]                   in_target_value,
  input  wire                                  in_auto_mode,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [12:0]                   out_drive,
  output logic                                 out_saturated,
  output logic                                 out_active,
  input  wire                                  cfg_we,
  input  wire         [fppr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire         [fppr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import fppr_pkg::*;

  // configuration
  logic signed [17:0] prop_gain_r;
  logic signed [18:0] integ_gain_r;
  logic signed [12:0] drive_low_r;
  logic signed [12:0] drive_high_r;
  logic        [12:0] db_width_r;

  // reciprocal divider
  logic               div_busy_r;
  logic        [3:0]  div_cnt_r;
  logic        [12:0] div_rem_r;
  logic        [12:0] div_den_r;
  logic        [12:0] recip_r;

  // regulator state
  logic signed [24:0] integ_r;
  logic signed [12:0] last_drive_r;
  logic               clamp_r;
  logic               running_r;

  // sequencer and datapath
  pc_t                pc_r;
  pc_t                pc_nxt;
  uword_t             uw;
  logic               on_r;
  logic signed [13:0] err_r;
  logic        [12:0] ea_r;
  logic signed [37:0] prod_r;
  logic signed [23:0] y_r;

  // output register
  logic               out_valid_r;
  logic signed [12:0] out_drive_r;
  logic               out_saturated_r;
  logic               out_active_r;

  logic               accept;
  logic               out_busy;
  logic               cond_hit;
  logic signed [12:0] meas_sat;
  logic signed [12:0] tgt_sat;
  logic signed [13:0] err_in;
  logic signed [23:0] mul_a;
  logic signed [13:0] mul_b;
  logic signed [37:0] mul_p;
  logic signed [24:0] hi25;
  logic signed [24:0] lo25;
  logic signed [37:0] it_sum;
  logic signed [37:0] it_clamp;
  logic signed [37:0] y_sum;
  logic signed [37:0] y_shr;
  logic        [12:0] cfg_db;
  logic        [13:0] div_sh;
  logic               div_ge;

  assign uw        = ucode(pc_r);
  assign in_ready  = (pc_r == STEP_WAIT) && !div_busy_r;
  assign accept    = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_saturated = out_saturated_r;
  assign out_active    = out_active_r;

  assign meas_sat = sat12(in_feedback);
  assign tgt_sat  = sat12(in_target_value);
  assign err_in   = 14'(tgt_sat) - 14'(meas_sat);

  always_comb begin
    case (uw.cond)
      C_NONE:     cond_hit = 1'b0;
      C_NO_ITEM:  cond_hit = !accept;
      C_MANUAL:   cond_hit = !on_r;
      C_NO_DB:    cond_hit = !((db_width_r != 13'd0) && (ea_r < db_width_r));
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      pc_nxt = uw.tgt;
    end else if (uw.last) begin
      pc_nxt = STEP_WAIT;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (uw.op)
      OP_MUL_I: begin
        mul_a = 24'(integ_gain_r);
        mul_b = err_r;
      end
      OP_MUL_P: begin
        mul_a = 24'(prop_gain_r);
        mul_b = err_r;
      end
      OP_MUL_S: begin
        mul_a = {11'd0, recip_r};
        mul_b = {1'b0, ea_r};
      end
      OP_MUL_D: begin
        mul_a = y_r;
        mul_b = prod_r[13:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign hi25 = {drive_high_r, 12'd0};
  assign lo25 = {drive_low_r, 12'd0};

  // integrator update: high clamp first, so the low limit wins when crossed
  always_comb begin
    it_sum   = 38'(integ_r) + (prod_r >>> 1);
    it_clamp = it_sum;
    if (it_clamp > 38'(hi25)) begin
      it_clamp = 38'(hi25);
    end
    if (it_clamp < 38'(lo25)) begin
      it_clamp = 38'(lo25);
    end
  end

  assign y_sum = prod_r + 38'(integ_r >>> 2);
  assign y_shr = y_sum >>> PROP_FRAC;

  assign cfg_db = (cfg_wdata[12:0] > DEADBAND_FULL) ? DEADBAND_FULL : cfg_wdata[12:0];

  // restoring division of 4096 by the deadband width, one quotient bit a cycle
  assign div_sh = {div_rem_r, (div_cnt_r == 4'd12)};
  assign div_ge = div_sh >= {1'b0, div_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      drive_low_r  <= '0;
      drive_high_r <= '0;
      db_width_r   <= '0;
      div_busy_r   <= 1'b0;
      div_cnt_r    <= '0;
      recip_r      <= '0;
    end else begin
      if (div_busy_r) begin
        div_rem_r <= div_ge ? 13'(div_sh - {1'b0, div_den_r}) : div_sh[12:0];
        recip_r   <= {recip_r[11:0], div_ge};
        div_cnt_r <= div_cnt_r - 4'd1;
        if (div_cnt_r == 4'd0) begin
          div_busy_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata[17:0];
          REG_INTEG_GAIN: integ_gain_r <= cfg_wdata[18:0];
          REG_DRIVE_LOW:  drive_low_r  <= cfg_wdata[12:0];
          REG_DRIVE_HIGH: drive_high_r <= cfg_wdata[12:0];
          REG_DEADBAND: begin
            db_width_r <= cfg_db;
            div_den_r  <= cfg_db;
            div_rem_r  <= '0;
            div_cnt_r  <= 4'd12;
            recip_r    <= '0;
            div_busy_r <= (cfg_db != 13'd0);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= STEP_WAIT;
      integ_r      <= '0;
      last_drive_r <= '0;
      clamp_r      <= 1'b0;
      running_r    <= 1'b0;
      on_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (uw.op)
        OP_LOAD: begin
          if (accept) begin
            on_r      <= in_auto_mode;
            running_r <= in_auto_mode;
            err_r     <= err_in;
            ea_r      <= err_in[13] ? 13'(-err_in) : err_in[12:0];
            // preset on a rise of auto for bumpless transfer
            if (in_auto_mode && !running_r) begin
              integ_r <= (integ_gain_r != 19'sd0) ? {last_drive_r, 12'd0} : 25'sd0;
            end
          end
        end
        OP_MUL_I, OP_MUL_P, OP_MUL_S: prod_r <= mul_p;
        OP_INTEG: integ_r <= it_clamp[24:0];
        OP_SUM:   y_r <= y_shr[23:0];
        OP_MUL_D: y_r <= 24'(mul_p >>> INTEG_FRAC);
        OP_CLAMP: begin
          if (y_r > 24'(drive_high_r)) begin
            last_drive_r <= drive_high_r;
            clamp_r      <= 1'b1;
          end else if (y_r < 24'(drive_low_r)) begin
            last_drive_r <= drive_low_r;
            clamp_r      <= 1'b1;
          end else begin
            last_drive_r <= y_r[12:0];
            clamp_r      <= 1'b0;
          end
        end
        OP_OUT: begin
          if (!out_busy) begin
            out_valid_r     <= 1'b1;
            out_drive_r     <= last_drive_r;
            out_saturated_r <= clamp_r;
            out_active_r    <= on_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
